[sv/jan_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants of the joystick axis normalizer
// no dependencies; imported by every module of the block but jan_serial_div

package jan_pkg;

  typedef logic [3:0]        reg_idx_t;
  typedef logic [3:0]        hat_dir_t;
  typedef logic signed [1:0] hat_unit_t;
  typedef logic [1:0]        axis_sel_t;

  localparam reg_idx_t REG_X_MIN  = 4'd0;
  localparam reg_idx_t REG_X_MAX  = 4'd1;
  localparam reg_idx_t REG_Y_MIN  = 4'd2;
  localparam reg_idx_t REG_Y_MAX  = 4'd3;
  localparam reg_idx_t REG_Z_MIN  = 4'd4;
  localparam reg_idx_t REG_Z_MAX  = 4'd5;
  localparam reg_idx_t REG_HAS_Z  = 4'd6;
  localparam reg_idx_t REG_HAS_HAT = 4'd7;

  localparam axis_sel_t AXIS_X = 2'd0;
  localparam axis_sel_t AXIS_Y = 2'd1;
  localparam axis_sel_t AXIS_Z = 2'd2;

  localparam int       HAT_DIRS   = 8;
  localparam hat_dir_t HAT_NONE   = 4'd8;
  localparam int       ANGLE_BITS = 16;
  localparam int       BTN_BITS   = 32;
  localparam int       BTN_KEEP   = 8;

  localparam logic [ANGLE_BITS-1:0] HAT_ANGLES [HAT_DIRS] = '{
    16'd0, 16'd4500, 16'd9000, 16'd13500, 16'd18000, 16'd22500, 16'd27000, 16'd31500
  };
  localparam hat_unit_t HAT_DX [HAT_DIRS] = '{
    2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1
  };
  localparam hat_unit_t HAT_DY [HAT_DIRS] = '{
    2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1
  };

  typedef struct packed {
    logic neg;
    logic zero;
  } axis_flags_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DONE
  } jan_state_t;

endpackage

[sv/jan_axis_prep.sv]
`timescale 1ns / 1ps
// clamps one raw axis to its calibration window and centers it
// uses jan_pkg for the flag struct; feeds jan_serial_div

module jan_axis_prep #(
  parameter int AXIS_BITS = 16
) (
  input  logic [AXIS_BITS-1:0] raw,
  input  logic [AXIS_BITS-1:0] lo,
  input  logic [AXIS_BITS-1:0] hi,
  output logic [AXIS_BITS-1:0] mag,
  output logic [AXIS_BITS-1:0] span,
  output jan_pkg::axis_flags_t flags
);
  import jan_pkg::*;

  logic [AXIS_BITS-1:0] clamped;
  logic [AXIS_BITS-1:0] off;
  logic [AXIS_BITS-1:0] half;

  always_comb begin
    span = hi - lo;
    half = span >> 1;
    if (raw < lo) begin
      clamped = lo;
    end else if (raw > hi) begin
      clamped = hi;
    end else begin
      clamped = raw;
    end
    off = clamped - lo;
    flags.zero = (hi <= lo);
    flags.neg  = (off < half);
    mag = flags.neg ? (half - off) : (off - half);
  end

endmodule

[sv/jan_serial_div.sv]
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
// computes (mag << (FRAC_BITS+1)) / divisor; no package needed

module jan_serial_div #(
  parameter int AXIS_BITS = 16,
  parameter int FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [AXIS_BITS-1:0] mag,
  input  logic [AXIS_BITS-1:0] divisor,
  output logic                 done,
  output logic [FRAC_BITS+1:0] quo
);
  localparam int QW = FRAC_BITS + 2;
  localparam int CW = $clog2(QW + 1);
  localparam logic [CW-1:0] LAST = CW'(QW - 1);

  logic [AXIS_BITS-1:0] rem_r;
  logic [AXIS_BITS-1:0] div_r;
  logic [QW-1:0]        quo_r;
  logic                 bit_r;
  logic [CW-1:0]        cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [AXIS_BITS:0]   sh;
  logic [AXIS_BITS:0]   sub;
  logic                 ge;

  always_comb begin
    sh  = {rem_r, bit_r};
    sub = sh - {1'b0, div_r};
    ge  = (sh >= {1'b0, div_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= mag >> 1;
      bit_r <= mag[0];
      div_r <= divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? sub[AXIS_BITS-1:0] : sh[AXIS_BITS-1:0];
      bit_r <= 1'b0;
      quo_r <= {quo_r[QW-2:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

[sv/jan_hat_decode.sv]
`timescale 1ns / 1ps
// maps a hat angle to one of eight compass directions and unit steps, or to HAT_NONE
// when there is no hat or no angle matches; uses the angle and unit tables of jan_pkg

module jan_hat_decode (
  input  logic [jan_pkg::ANGLE_BITS-1:0] angle,
  input  logic                           has_hat,
  output jan_pkg::hat_dir_t              dir,
  output jan_pkg::hat_unit_t             dx,
  output jan_pkg::hat_unit_t             dy
);
  import jan_pkg::*;

  always_comb begin
    dir = HAT_NONE;
    dx  = 2'sd0;
    dy  = 2'sd0;
    if (has_hat) begin
      for (int k = 0; k < HAT_DIRS; k++) begin
        if (angle == HAT_ANGLES[k]) begin
          dir = hat_dir_t'(k);
          dx  = HAT_DX[k];
          dy  = HAT_DY[k];
        end
      end
    end
  end

endmodule

[sv/joystick_axis_normalizer.sv]
`timescale 1ns / 1ps
// Joystick axis normalizer: one poll sample in, at most one calibrated result out,
// emitted only when the stick is present and the buttons or an axis changed. Axes are
// clamped, centered and scaled to signed values with FRAC_BITS fraction bits, saturated
// to +-2^FRAC_BITS. The three axes share one bit-serial divider that yields one quotient
// bit per cycle, so the axes of a sample are worked on one after another; an axis with an
// empty range, or Z without a Z axis, skips the divider and gives zero. A sample with the
// stick absent gives no result.
// The next sample is taken once the previous one is finished, even while its result waits.
// Depends on jan_pkg, jan_axis_prep, jan_serial_div and jan_hat_decode.

module joystick_axis_normalizer #(
  parameter int AXIS_BITS = 16,
  parameter int FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [AXIS_BITS-1:0]              in_raw_x,
  input  logic [AXIS_BITS-1:0]              in_raw_y,
  input  logic [AXIS_BITS-1:0]              in_raw_z,
  input  logic [jan_pkg::BTN_BITS-1:0]      in_button_word,
  input  logic [jan_pkg::ANGLE_BITS-1:0]    in_hat_angle,
  input  logic                              in_stick_present,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [FRAC_BITS+1:0]       out_norm_x,
  output logic signed [FRAC_BITS+1:0]       out_norm_y,
  output logic signed [FRAC_BITS+1:0]       out_norm_z,
  output logic [jan_pkg::BTN_KEEP-1:0]      out_buttons_low,
  output jan_pkg::hat_dir_t                 out_hat_direction,
  output jan_pkg::hat_unit_t                out_hat_dx,
  output jan_pkg::hat_unit_t                out_hat_dy,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  jan_pkg::reg_idx_t                 cfg_index,
  input  logic [AXIS_BITS-1:0]              cfg_data
);
  import jan_pkg::*;

  localparam int NW = FRAC_BITS + 2;
  localparam logic [NW-1:0] LIM = NW'(1) << FRAC_BITS;
  localparam logic signed [NW-1:0] LIM_S = LIM;

  // calibration
  logic [AXIS_BITS-1:0] x_min_r, x_max_r, y_min_r, y_max_r, z_min_r, z_max_r;
  logic                 has_z_r, has_hat_r;

  // captured request
  logic [AXIS_BITS-1:0]  raw_r [3];
  logic [BTN_KEEP-1:0]   btn_r;
  logic [ANGLE_BITS-1:0] angle_r;

  // per-axis results and change history
  logic signed [NW-1:0] res_r [3];
  logic                 neg_r;
  logic [BTN_KEEP-1:0]  last_btn_r;
  logic signed [NW-1:0] last_x_r, last_y_r, last_z_r;

  // output register
  logic                 out_valid_r;
  logic signed [NW-1:0] out_x_r, out_y_r, out_z_r;
  logic [BTN_KEEP-1:0]  out_btn_r;
  hat_dir_t             out_dir_r;
  hat_unit_t            out_dx_r, out_dy_r;

  jan_state_t state_r, state_nxt;
  axis_sel_t  ax_r, ax_nxt;

  // control
  logic capture, div_start, res_we_zero, res_we_div, load_out;

  logic [AXIS_BITS-1:0] sel_raw, sel_lo, sel_hi, mag, span;
  axis_flags_t          flags;
  logic                 div_done;
  logic [NW-1:0]        quo, sat;
  logic signed [NW-1:0] div_val;
  logic                 skip_axis, changed, slot_free;
  hat_dir_t             hat_dir;
  hat_unit_t            hat_dx, hat_dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r   <= '0;
      x_max_r   <= '1;
      y_min_r   <= '0;
      y_max_r   <= '1;
      z_min_r   <= '0;
      z_max_r   <= '1;
      has_z_r   <= 1'b0;
      has_hat_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_X_MIN:   x_min_r   <= cfg_data;
        REG_X_MAX:   x_max_r   <= cfg_data;
        REG_Y_MIN:   y_min_r   <= cfg_data;
        REG_Y_MAX:   y_max_r   <= cfg_data;
        REG_Z_MIN:   z_min_r   <= cfg_data;
        REG_Z_MAX:   z_max_r   <= cfg_data;
        REG_HAS_Z:   has_z_r   <= cfg_data[0];
        REG_HAS_HAT: has_hat_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    case (ax_r)
      AXIS_X: begin
        sel_lo = x_min_r;
        sel_hi = x_max_r;
      end
      AXIS_Y: begin
        sel_lo = y_min_r;
        sel_hi = y_max_r;
      end
      default: begin
        sel_lo = z_min_r;
        sel_hi = z_max_r;
      end
    endcase
    sel_raw = raw_r[ax_r];
  end

  jan_axis_prep #(.AXIS_BITS(AXIS_BITS)) u_prep (
    .raw   (sel_raw),
    .lo    (sel_lo),
    .hi    (sel_hi),
    .mag   (mag),
    .span  (span),
    .flags (flags)
  );

  jan_serial_div #(.AXIS_BITS(AXIS_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .mag     (mag),
    .divisor (span),
    .done    (div_done),
    .quo     (quo)
  );

  jan_hat_decode u_hat (
    .angle   (angle_r),
    .has_hat (has_hat_r),
    .dir     (hat_dir),
    .dx      (hat_dx),
    .dy      (hat_dy)
  );

  always_comb begin
    sat       = (quo > LIM) ? LIM : quo;
    div_val   = neg_r ? -$signed(sat) : $signed(sat);
    skip_axis = flags.zero || ((ax_r == AXIS_Z) && !has_z_r);
    changed   = (btn_r != last_btn_r) || (res_r[0] != last_x_r) ||
                (res_r[1] != last_y_r) || (res_r[2] != last_z_r);
    slot_free = !out_valid_r || !out_stall;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    ax_nxt    = ax_r;
    case (state_r)
      S_IDLE: begin
        ax_nxt = AXIS_X;
        if (in_valid && in_stick_present) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        if (skip_axis) begin
          if (ax_r == AXIS_Z) begin
            state_nxt = S_DONE;
          end else begin
            ax_nxt = ax_r + 2'd1;
          end
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (ax_r == AXIS_Z) begin
            state_nxt = S_DONE;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = S_PREP;
          end
        end
      end
      S_DONE: begin
        if (!changed || slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    capture     = 1'b0;
    div_start   = 1'b0;
    res_we_zero = 1'b0;
    res_we_div  = 1'b0;
    load_out    = 1'b0;
    in_stall    = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        capture  = in_valid;
      end
      S_PREP: begin
        res_we_zero = skip_axis;
        div_start   = !skip_axis;
      end
      S_DIV:  res_we_div = div_done;
      S_DONE: load_out   = changed && slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ax_r    <= AXIS_X;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      raw_r[0] <= in_raw_x;
      raw_r[1] <= in_raw_y;
      raw_r[2] <= in_raw_z;
      btn_r    <= in_button_word[BTN_KEEP-1:0];
      angle_r  <= in_hat_angle;
    end
    if (div_start) begin
      neg_r <= flags.neg;
    end
    if (res_we_zero) begin
      res_r[ax_r] <= '0;
    end else if (res_we_div) begin
      res_r[ax_r] <= div_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_btn_r  <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_z_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) begin
        last_btn_r  <= btn_r;
        last_x_r    <= res_r[0];
        last_y_r    <= res_r[1];
        last_z_r    <= res_r[2];
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x_r   <= res_r[0];
      out_y_r   <= res_r[1];
      out_z_r   <= res_r[2];
      out_btn_r <= btn_r;
      out_dir_r <= hat_dir;
      out_dx_r  <= hat_dx;
      out_dy_r  <= hat_dy;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_norm_x        = out_x_r;
  assign out_norm_y        = out_y_r;
  assign out_norm_z        = out_z_r;
  assign out_buttons_low   = out_btn_r;
  assign out_hat_direction = out_dir_r;
  assign out_hat_dx        = out_dx_r;
  assign out_hat_dy        = out_dy_r;

  // divider only runs while an axis is being worked on
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !div_done)
    else $error("divider finished outside an axis slot");

  // a new result only comes from the finish state with a change seen
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE && changed))
    else $error("result loaded without a detected change");

  // emitted axes stay inside the saturation bounds
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_x_r <= LIM_S && out_x_r >= -LIM_S &&
                     out_y_r <= LIM_S && out_y_r >= -LIM_S &&
                     out_z_r <= LIM_S && out_z_r >= -LIM_S))
    else $error("normalized axis beyond saturation bound");

  // without a Z axis the emitted Z value is zero
  a_no_z: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && !has_z_r |-> (out_z_r == '0))
    else $error("Z value emitted without a Z axis");

endmodule
